// File: sv/mos_pkg.sv
package mos_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned AddrW    = $clog2(MaxItems);
  localparam int unsigned CountW   = $clog2(MaxItems + 1);
  localparam int unsigned DataW    = 32;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StTooFew  = 2'd1,
    StTooMany = 2'd2
  } status_e;

endpackage

// File: sv/median_of_set.sv
// Insert: a value is placed in sorted order by walking down from the top of the set;
// each stored value larger than it is shifted up one slot. The first value of a set, or
// one that finds the store full, is taken in the idle state. One read-compare-write per shifted entry.
// Set end: for a valid set the middle entry or pair is read and the result register loaded;
// the result then waits in SEmit while the previous result is still held in the output register.
// Reset clears count, overflow flag, FSM and output valid; the sample memory needs no clearing.
module median_of_set (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [mos_pkg::DataW-1:0]   sample_value_i,
  input  logic                               is_last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mos_pkg::DataW-1:0]   median_value_o,
  output logic        [1:0]                  status_o
);

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SPlace,
    SFinish,
    SRd1,
    SRd2,
    SEmit
  } state_e;

  state_e                           state_q;
  mos_pkg::count_t                  count_q;
  logic                             ovf_q;
  mos_pkg::addr_t                   pos_q;
  logic signed [mos_pkg::DataW-1:0] val_q;
  logic                             last_q;
  logic signed [mos_pkg::DataW-1:0] a_q;
  logic signed [mos_pkg::DataW-1:0] med_q;
  mos_pkg::status_e                 status_q;
  logic                             out_valid_q;
  logic signed [mos_pkg::DataW-1:0] out_med_q;
  mos_pkg::status_e                 out_status_q;

  logic signed [mos_pkg::DataW-1:0] mem [mos_pkg::MaxItems];
  logic signed [mos_pkg::DataW-1:0] rdata_q;
  logic                             we;
  mos_pkg::addr_t                   waddr;
  logic signed [mos_pkg::DataW-1:0] wdata;
  logic                             re;
  mos_pkg::addr_t                   raddr;

  logic                             in_xfer;
  logic                             full;
  mos_pkg::addr_t                   half;
  logic                             even;
  logic                             emit_ok;
  logic        [mos_pkg::DataW:0]   pair_sum;

  assign in_ready_o = (state_q == SIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign full       = (count_q == mos_pkg::count_t'(mos_pkg::MaxItems));
  assign half       = count_q[mos_pkg::CountW-1:1];
  assign even       = ~count_q[0];
  assign emit_ok    = !out_valid_q || out_ready_i;
  assign pair_sum   = {a_q[mos_pkg::DataW-1], a_q} + {rdata_q[mos_pkg::DataW-1], rdata_q};

  assign out_valid_o    = out_valid_q;
  assign median_value_o = out_med_q;
  assign status_o       = out_status_q;

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = pos_q;
    wdata = val_q;
    re    = 1'b0;
    raddr = pos_q;
    unique case (state_q)
      SIdle: begin
        if (in_xfer && !full) begin
          if (count_q == '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = sample_value_i;
          end else begin
            re    = 1'b1;
            raddr = count_q[mos_pkg::AddrW-1:0] - 1'b1;
          end
        end
      end
      SScan: begin
        we    = 1'b1;
        waddr = pos_q;
        if (rdata_q > val_q) begin
          wdata = rdata_q;
          if (pos_q != mos_pkg::addr_t'(1)) begin
            re    = 1'b1;
            raddr = pos_q - mos_pkg::addr_t'(2);
          end
        end else begin
          wdata = val_q;
        end
      end
      SPlace: begin
        we    = 1'b1;
        waddr = '0;
        wdata = val_q;
      end
      SFinish: begin
        if (!ovf_q && count_q >= mos_pkg::count_t'(2)) begin
          re    = 1'b1;
          raddr = even ? half - 1'b1 : half;
        end
      end
      SRd1: begin
        if (even) begin
          re    = 1'b1;
          raddr = half;
        end
      end
      SRd2, SEmit: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      val_q  <= sample_value_i;
      last_q <= is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      pos_q        <= '0;
      a_q          <= '0;
      med_q        <= '0;
      status_q     <= mos_pkg::StOk;
      out_valid_q  <= 1'b0;
      out_med_q    <= '0;
      out_status_q <= mos_pkg::StOk;
    end else begin
      // the emit state loads the next result itself
      if (out_valid_q && out_ready_i && state_q != SEmit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (in_xfer) begin
            if (full) begin
              ovf_q   <= 1'b1;
              state_q <= is_last_i ? SFinish : SIdle;
            end else if (count_q == '0) begin
              count_q <= count_q + 1'b1;
              state_q <= is_last_i ? SFinish : SIdle;
            end else begin
              pos_q   <= count_q[mos_pkg::AddrW-1:0];
              state_q <= SScan;
            end
          end
        end
        SScan: begin
          if (rdata_q > val_q) begin
            // shift entry up one slot and keep walking down
            pos_q <= pos_q - 1'b1;
            if (pos_q == mos_pkg::addr_t'(1)) begin
              state_q <= SPlace;
            end
          end else begin
            count_q <= count_q + 1'b1;
            state_q <= last_q ? SFinish : SIdle;
          end
        end
        SPlace: begin
          count_q <= count_q + 1'b1;
          state_q <= last_q ? SFinish : SIdle;
        end
        SFinish: begin
          med_q <= '0;
          priority if (ovf_q) begin
            status_q <= mos_pkg::StTooMany;
            state_q  <= SEmit;
          end else if (count_q < mos_pkg::count_t'(2)) begin
            status_q <= mos_pkg::StTooFew;
            state_q  <= SEmit;
          end else begin
            status_q <= mos_pkg::StOk;
            state_q  <= SRd1;
          end
        end
        SRd1: begin
          if (even) begin
            a_q     <= rdata_q;
            state_q <= SRd2;
          end else begin
            med_q   <= rdata_q;
            state_q <= SEmit;
          end
        end
        SRd2: begin
          med_q   <= pair_sum[mos_pkg::DataW:1];
          state_q <= SEmit;
        end
        SEmit: begin
          if (emit_ok) begin
            out_valid_q  <= 1'b1;
            out_med_q    <= med_q;
            out_status_q <= status_q;
            count_q      <= '0;
            ovf_q        <= 1'b0;
            state_q      <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mos_pkg::count_t'(mos_pkg::MaxItems))
    else $error("sample count above capacity");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flag set with store not full");

  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> ({1'b0, pos_q} <= count_q && pos_q != '0))
    else $error("insert position out of range");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEmit && emit_ok) |=> (count_q == '0 && !ovf_q && out_valid_q))
    else $error("set state not cleared after result");
`endif

endmodule
